FILE: sv/mse_pkg.sv
// shared types, command and opcode codes for the execute unit
// no dependencies; used by every module of the block
package mse_pkg;

	// item commands
	typedef enum logic [1:0] {
		CMD_EXEC      = 2'd0,
		CMD_PRELOAD   = 2'd1,
		CMD_READ_REG  = 2'd2,
		CMD_READ_WORD = 2'd3
	} cmd_t;

	// instruction formats, bits 31:29
	localparam logic [2:0] FMT_CTRL = 3'b001;
	localparam logic [2:0] FMT_REG  = 3'b010;
	localparam logic [2:0] FMT_IMM  = 3'b100;

	// control format opcodes
	localparam logic [2:0] CT_NOP  = 3'd0;
	localparam logic [2:0] CT_J    = 3'd1;
	localparam logic [2:0] CT_BEQ  = 3'd2;
	localparam logic [2:0] CT_BNE  = 3'd3;
	localparam logic [2:0] CT_BGTZ = 3'd4;
	localparam logic [2:0] CT_SW   = 3'd5;
	localparam logic [2:0] CT_LW   = 3'd6;

	// register format opcodes
	localparam logic [2:0] RG_XOR  = 3'd0;
	localparam logic [2:0] RG_MUL  = 3'd1;
	localparam logic [2:0] RG_ADD  = 3'd2;
	localparam logic [2:0] RG_SUB  = 3'd3;
	localparam logic [2:0] RG_AND  = 3'd4;
	localparam logic [2:0] RG_OR   = 3'd5;
	localparam logic [2:0] RG_ADDU = 3'd6;

	// immediate format opcodes
	localparam logic [2:0] IM_ORI  = 3'd0;
	localparam logic [2:0] IM_XORI = 3'd1;
	localparam logic [2:0] IM_ADDI = 3'd2;
	localparam logic [2:0] IM_SUBI = 3'd3;
	localparam logic [2:0] IM_ANDI = 3'd4;
	localparam logic [2:0] IM_SRL  = 3'd5;
	localparam logic [2:0] IM_SRA  = 3'd6;

	localparam logic [31:0] BREAK_WORD = 32'h3C00_000D;
	localparam logic [31:0] PC_STEP    = 32'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] instr_word;
		logic [31:0] instr_pc;
		logic [4:0]  reg_select;
		logic [7:0]  word_index;
		logic [31:0] word_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        next_pc;
		logic               taken;
		logic               halted;
		logic               reg_written;
		logic [4:0]         reg_index;
		logic signed [31:0] reg_value;
		logic               mem_written;
		logic [7:0]         mem_index;
		logic signed [31:0] mem_value;
		logic               fault;
		logic               illegal;
	} out_item_t;

	// execute stage result toward the pipeline control
	typedef struct packed {
		out_item_t   res;
		logic        dm_we;
		logic [31:0] dm_wdata;
		logic        ld;
		logic        rdw;
		logic        set_halt;
	} exec_res_t;

	// register file read port 0: rs, the second source of a register op, or the read-back register
	function automatic logic [4:0] rf_addr0(in_item_t it);
		logic [4:0] a;
		if (it.command == CMD_READ_REG) begin
			a = it.reg_select;
		end else if (it.instr_word[31:29] == FMT_REG) begin
			a = it.instr_word[15:11];
		end else begin
			a = it.instr_word[25:21];
		end
		return a;
	endfunction

	// register file read port 1: rt
	function automatic logic [4:0] rf_addr1(in_item_t it);
		return it.instr_word[20:16];
	endfunction

endpackage

FILE: sv/mse_regfile.sv
// 32 x 32 register file, two registered read ports and one write port
// depends on mse_pkg; entries read as zero until first written
module mse_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        re,
	input  logic [4:0]  raddr0,
	input  logic [4:0]  raddr1,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	output logic [31:0] rdata0,
	output logic [31:0] rdata1
);
	import mse_pkg::*;

	logic [31:0] mem [32];
	logic [31:0] vld_q;
	logic [31:0] rd0_q, rd1_q;
	logic        rv0_q, rv1_q;

	// storage array, read before write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd0_q <= mem[raddr0];
			rd1_q <= mem[raddr1];
		end
	end

	// per-entry valid bits stand in for the reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv0_q <= 1'b0;
			rv1_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rv0_q <= vld_q[raddr0];
				rv1_q <= vld_q[raddr1];
			end
		end
	end

	assign rdata0 = rv0_q ? rd0_q : '0;
	assign rdata1 = rv1_q ? rd1_q : '0;

endmodule

FILE: sv/mse_dmem.sv
// single-port data word memory with registered read
// depends on mse_pkg; contents undefined until written
module mse_dmem #(
	parameter int DATA_WORDS = 256,
	localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  we,
	input  logic [AW-1:0]         addr,
	input  logic [31:0]           wdata,
	output logic [31:0]           rdata
);
	import mse_pkg::*;

	logic [31:0] mem [DATA_WORDS];
	logic [31:0] rd_q;

	// one access per cycle: write or read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_q;

endmodule

FILE: sv/mse_exec.sv
// decode and execute of one item: alu, branch, address map
// depends on mse_pkg; operands arrive already forwarded
module mse_exec #(
	parameter int DATA_WORDS = 256,
	localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1
) (
	input  mse_pkg::in_item_t  item,
	input  logic [31:0]        op_a,
	input  logic [31:0]        op_b,
	input  logic               halt,
	input  logic [31:0]        data_base,
	output mse_pkg::exec_res_t ex,
	output logic [AW-1:0]      dm_addr
);
	import mse_pkg::*;

	logic [31:0] w, seq, simm, zimm, btgt, off, wv;
	logic [2:0]  fmt, op;
	logic [4:0]  sa;
	logic        addr_ok, wr;

	always_comb begin
		w       = item.instr_word;
		fmt     = w[31:29];
		op      = w[28:26];
		sa      = w[4:0];
		seq     = item.instr_pc + PC_STEP;
		simm    = {{16{w[15]}}, w[15:0]};
		zimm    = {16'h0000, w[15:0]};
		btgt    = seq + (simm << 2);
		off     = op_a + simm - data_base;
		addr_ok = (off[1:0] == 2'b00) && ({2'b00, off[31:2]} < 32'(DATA_WORDS));
		wv      = '0;
		wr      = 1'b0;
		ex      = '0;
		dm_addr = '0;
		ex.res.halted = halt;

		case (item.command)
			// preload and read back of a data word
			CMD_PRELOAD, CMD_READ_WORD: begin
				dm_addr = AW'(item.word_index);
				if ({24'h0, item.word_index} >= 32'(DATA_WORDS)) begin
					ex.res.fault = 1'b1;
				end else begin
					ex.res.mem_index = item.word_index;
					if (item.command == CMD_PRELOAD) begin
						ex.dm_we           = 1'b1;
						ex.dm_wdata        = item.word_value;
						ex.res.mem_written = 1'b1;
						ex.res.mem_value   = $signed(item.word_value);
					end else begin
						ex.rdw = 1'b1;
					end
				end
			end
			// register read back
			CMD_READ_REG: begin
				ex.res.reg_index = item.reg_select;
				ex.res.reg_value = $signed(op_a);
			end
			default: begin
				if (halt) begin
					ex.res.next_pc = item.instr_pc;
				end else if (w == BREAK_WORD) begin
					ex.set_halt    = 1'b1;
					ex.res.halted  = 1'b1;
					ex.res.next_pc = item.instr_pc;
				end else begin
					ex.res.next_pc = seq;
					if (fmt == FMT_CTRL) begin
						// jumps, branches, loads and stores
						dm_addr = AW'(off[31:2]);
						case (op)
							CT_NOP: ;
							CT_J: begin
								ex.res.taken   = 1'b1;
								ex.res.next_pc = {seq[31:28], w[25:0], 2'b00};
							end
							CT_BEQ: begin
								if (op_a == op_b) begin
									ex.res.taken   = 1'b1;
									ex.res.next_pc = btgt;
								end
							end
							CT_BNE: begin
								if (op_a != op_b) begin
									ex.res.taken   = 1'b1;
									ex.res.next_pc = btgt;
								end
							end
							CT_BGTZ: begin
								if (op_a != '0 && !op_a[31]) begin
									ex.res.taken   = 1'b1;
									ex.res.next_pc = btgt;
								end
							end
							CT_SW: begin
								if (addr_ok) begin
									ex.dm_we           = 1'b1;
									ex.dm_wdata        = op_b;
									ex.res.mem_written = 1'b1;
									ex.res.mem_index   = off[9:2];
									ex.res.mem_value   = $signed(op_b);
								end else begin
									ex.res.fault = 1'b1;
								end
							end
							CT_LW: begin
								if (addr_ok) begin
									ex.ld                = 1'b1;
									ex.res.reg_written   = 1'b1;
									ex.res.reg_index     = w[20:16];
									ex.res.mem_index     = off[9:2];
								end else begin
									ex.res.fault = 1'b1;
								end
							end
							default: ex.res.illegal = 1'b1;
						endcase
					end else if (fmt == FMT_REG) begin
						// rs = rt op rd; op_b is rt, op_a is rd
						wr = 1'b1;
						case (op)
							RG_XOR:  wv = op_b ^ op_a;
							RG_MUL:  wv = 32'(op_b * op_a);
							RG_ADD:  wv = op_b + op_a;
							RG_SUB:  wv = op_b - op_a;
							RG_AND:  wv = op_b & op_a;
							RG_OR:   wv = op_b | op_a;
							RG_ADDU: wv = op_b + op_a;
							default: wv = op_b - op_a;
						endcase
					end else if (fmt == FMT_IMM) begin
						// rs = rt op immediate or shift
						wr = 1'b1;
						case (op)
							IM_ORI:  wv = op_b | zimm;
							IM_XORI: wv = op_b ^ zimm;
							IM_ADDI: wv = op_b + simm;
							IM_SUBI: wv = op_b - simm;
							IM_ANDI: wv = op_b & zimm;
							IM_SRL:  wv = op_b >> sa;
							IM_SRA:  wv = $unsigned($signed(op_b) >>> sa);
							default: wv = op_b << sa;
						endcase
					end else begin
						ex.res.illegal = 1'b1;
					end
					if (wr) begin
						ex.res.reg_written = 1'b1;
						ex.res.reg_index   = w[25:21];
						ex.res.reg_value   = $signed(wv);
					end
				end
			end
		endcase
	end

endmodule

FILE: sv/mips_subset_execute_unit.sv
// Execute unit for a small MIPS-like instruction subset. One item enters per
// clock when the output side keeps up; each item gives exactly one result
// item: the register file is read at the edge that accepts it, then the
// item is executed with the data memory access, then the result is written
// back into the output register. The register file and the data memory
// are synchronous memories with registered reads; register results not yet
// written back are forwarded from the memory stage and from the writeback
// of the previous cycle, so dependent instructions run back to back without
// interlock. The register file reads as zero after reset; data memory words
// are undefined until preloaded or stored. A stall on the output freezes the
// whole pipeline and holds off the input.
// depends on mse_pkg, mse_regfile, mse_dmem and mse_exec
module mips_subset_execute_unit #(
	parameter int DATA_WORDS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  mse_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output mse_pkg::out_item_t out_item
);
	import mse_pkg::*;

	localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

	logic        adv;
	logic [31:0] data_base_q;
	logic        halt_q;

	logic        vld_s1, vld_s2, out_vld_q;
	in_item_t    item_s1;
	out_item_t   res_s2, fin_s2, out_q;
	logic        ld_s2, rdw_s2;

	logic [31:0] rf_rd0, rf_rd1, op_a, op_b;
	logic [4:0]  ra0, ra1;
	logic        wb_vld_q;
	logic [4:0]  wb_idx_q;
	logic [31:0] wb_val_q;
	logic        s2_wr;

	exec_res_t   ex;
	logic [AW-1:0] dm_addr;
	logic [31:0] dm_rdata;

	// pipeline moves as a whole when the output register can take an item
	assign adv       = !out_vld_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q <= '0;
		end else if (cfg_wr_en) begin
			data_base_q <= cfg_wr_data;
		end
	end

	mse_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (adv),
		.raddr0 (rf_addr0(in_item)),
		.raddr1 (rf_addr1(in_item)),
		.we     (adv && s2_wr),
		.waddr  (fin_s2.reg_index),
		.wdata  ($unsigned(fin_s2.reg_value)),
		.rdata0 (rf_rd0),
		.rdata1 (rf_rd1)
	);

	// operand forwarding: memory stage first, then last writeback
	always_comb begin
		ra0  = rf_addr0(item_s1);
		ra1  = rf_addr1(item_s1);
		op_a = rf_rd0;
		op_b = rf_rd1;
		if (wb_vld_q && wb_idx_q == ra0) begin
			op_a = wb_val_q;
		end
		if (wb_vld_q && wb_idx_q == ra1) begin
			op_b = wb_val_q;
		end
		if (s2_wr && fin_s2.reg_index == ra0) begin
			op_a = $unsigned(fin_s2.reg_value);
		end
		if (s2_wr && fin_s2.reg_index == ra1) begin
			op_b = $unsigned(fin_s2.reg_value);
		end
	end

	mse_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
		.item      (item_s1),
		.op_a      (op_a),
		.op_b      (op_b),
		.halt      (halt_q),
		.data_base (data_base_q),
		.ex        (ex),
		.dm_addr   (dm_addr)
	);

	mse_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.en    (adv),
		.we    (adv && vld_s1 && ex.dm_we),
		.addr  (dm_addr),
		.wdata (ex.dm_wdata),
		.rdata (dm_rdata)
	);

	// merge the loaded or read-back word into the memory stage result
	always_comb begin
		fin_s2 = res_s2;
		if (ld_s2) begin
			fin_s2.reg_value = $signed(dm_rdata);
			fin_s2.mem_value = $signed(dm_rdata);
		end
		if (rdw_s2) begin
			fin_s2.mem_value = $signed(dm_rdata);
		end
	end
	assign s2_wr = vld_s2 && fin_s2.reg_written;

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= in_item;
			res_s2   <= ex.res;
			ld_s2    <= ex.ld;
			rdw_s2   <= ex.rdw;
			out_q    <= fin_s2;
			wb_idx_q <= fin_s2.reg_index;
			wb_val_q <= $unsigned(fin_s2.reg_value);
		end
	end

	// pipeline control and sticky halt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			wb_vld_q  <= 1'b0;
			halt_q    <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
			wb_vld_q  <= s2_wr;
			if (vld_s1 && ex.set_halt) begin
				halt_q <= 1'b1;
			end
		end
	end

endmodule

FILE: sv/mse_checker.sv
// port-level checks for the execute unit, bound to the top level
// depends on mse_pkg and mips_subset_execute_unit
module mse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input mse_pkg::out_item_t out_item
);
	import mse_pkg::*;

	logic seen_halt_q;

	// remember a delivered halted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (out_valid && !out_stall && out_item.halted) begin
			seen_halt_q <= 1'b1;
		end
	end

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed under stall");

	// halt is sticky across delivered items
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_halt_q |-> out_item.halted)
		else $error("halt flag dropped");

	// a faulting or illegal item writes nothing
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.fault || out_item.illegal) |->
			!out_item.reg_written && !out_item.mem_written)
		else $error("write reported with fault or illegal");

	// a redirect never writes state or faults
	a_taken_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.taken |->
			!out_item.reg_written && !out_item.mem_written && !out_item.fault)
		else $error("taken item reports a write");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
